### rtl/assert_macros.svh
// Assertion macros shared by the checker files of the project.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CMB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cmb assertion failed");

// Next-cycle implication, sampled on the rising clock edge.
`define CMB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cmb assertion failed");

`endif

### rtl/cmb_pkg.sv
// Shared types and constants of the five-point cross mean filter.
// No dependencies; imported by every module of the filter.
package cmb_pkg;

   localparam int PIXEL_W        = 8;
   localparam int FRAME_WIDTH_W  = 12;
   localparam int FRAME_HEIGHT_W = 13;
   localparam int CSR_DATA_W     = 13;
   localparam int CSR_INDEX_W    = 2;

   // Register indexes of the configuration port.
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd1;

   // Values after reset.
   localparam logic [FRAME_WIDTH_W-1:0]  FRAME_WIDTH_RESET  = 12'd1280;
   localparam logic [FRAME_HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 13'd720;

   // Five-point sum and exact division by five through a reciprocal.
   // For sums up to 1275, (sum * 13108) >> 16 equals floor(sum / 5).
   localparam int                  SUM_W       = PIXEL_W + 3;
   localparam int                  RECIP_W     = 14;
   localparam logic [RECIP_W-1:0]  RECIP_FIVE  = 14'd13108;
   localparam int                  RECIP_SHIFT = 16;
   localparam int                  PROD_W      = SUM_W + RECIP_W;

   // One line-store word: the row two back and the row one back at a column.
   typedef struct packed {
      logic [PIXEL_W-1:0] upper;
      logic [PIXEL_W-1:0] middle;
   } line_word_type;

   // The five pixels around one output position, zero where outside the frame.
   typedef struct packed {
      logic [PIXEL_W-1:0] top;
      logic [PIXEL_W-1:0] left;
      logic [PIXEL_W-1:0] center;
      logic [PIXEL_W-1:0] right;
      logic [PIXEL_W-1:0] bottom;
   } window_type;

endpackage

### rtl/cmb_line_store.sv
// Line store of the cross mean filter: one write port and one registered read port.
// Depends on cmb_pkg for the word type.
module cmb_line_store
   import cmb_pkg::*;
#(
   parameter int DEPTH  = 2048,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic                clock,
   input  logic                write_enable,
   input  logic [ADDR_W-1:0]   write_address,
   input  line_word_type       write_data,
   input  logic                read_enable,
   input  logic [ADDR_W-1:0]   read_address,
   output line_word_type       read_data
);

   line_word_type mem [DEPTH];
   line_word_type read_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (write_enable) begin
         mem[write_address] <= write_data;
      end
   end

   // Read port; a read of the word written in the same cycle returns the new word.
   always_ff @(posedge clock) begin
      if (read_enable) begin
         if (write_enable && (write_address == read_address)) begin
            read_data_ff <= write_data;
         end else begin
            read_data_ff <= mem[read_address];
         end
      end
   end

   assign read_data = read_data_ff;

endmodule

### rtl/cmb_mean5.sv
// Five-point sum and truncating divide by five of the cross mean filter.
// Depends on cmb_pkg for the window type and the reciprocal constant.
module cmb_mean5
   import cmb_pkg::*;
(
   input  window_type          window,
   output logic [PIXEL_W-1:0]  mean
);

   logic [SUM_W-1:0]  sum;
   logic [PROD_W-1:0] product;

   // Sum of the five pixels, then the multiply by the reciprocal of five.
   always_comb begin
      sum = SUM_W'(window.top) + SUM_W'(window.left) + SUM_W'(window.center)
          + SUM_W'(window.right) + SUM_W'(window.bottom);
      product = PROD_W'(sum) * PROD_W'(RECIP_FIVE);
      mean = product[RECIP_SHIFT +: PIXEL_W];
   end

endmodule

### rtl/cross_mean_blur_filter.sv
// Top level of the five-point cross mean filter: scan counters, window and result register.
// Depends on cmb_pkg, cmb_line_store and cmb_mean5.
//
// Takes one pixel per clock in raster order and gives floor((center + left + right + up
// + down) / 5), with neighbors outside the frame counted as zero. Results lag the input by
// one row: the first row of a frame gives no results, and every later beat gives the result
// for the pixel one row above it. After the last row, send frame_width flush beats (their
// pixel value is ignored) to drain the last row; the counters then wrap to the next frame.
// The row count alone decides what is a flush beat. One beat is accepted in every cycle
// that the result register is empty or being taken; a result that waits in that
// register holds up the input. The two rows above live in one line store of
// WIDTH_MAX words of 16 bits with one write and one read port, read two columns ahead,
// so the scan does not pause at row ends. Any write to frame_width or frame_height
// restarts the frame at row 0, column 0; write them only while the filter is idle.
module cross_mean_blur_filter
   import cmb_pkg::*;
#(
   parameter int WIDTH_MAX  = 2048,
   parameter int HEIGHT_MAX = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [PIXEL_W-1:0]        req_pixel_value,
   input  logic                      req_flush,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [PIXEL_W-1:0]        rsp_blurred_value,
   output logic                      rsp_end_of_row,
   output logic                      rsp_end_of_frame,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   localparam int CW  = $clog2(WIDTH_MAX);
   localparam int WCW = $clog2(WIDTH_MAX + 1);
   localparam int RW  = $clog2(HEIGHT_MAX + 1);

   // Configuration registers.
   logic [FRAME_WIDTH_W-1:0]  frame_width_ff, frame_width_in;
   logic [FRAME_HEIGHT_W-1:0] frame_height_ff, frame_height_in;
   logic [WCW-1:0]            eff_width;
   logic [RW-1:0]             eff_height;

   // Scan position.
   logic [CW-1:0]  col_ff, col_in;
   logic [RW-1:0]  row_ff, row_in;
   logic [WCW-1:0] col_plus1;
   logic [WCW-1:0] next1_plus1;
   logic [CW-1:0]  next1_col, next2_col;
   logic           last_col;

   // Window registers and line store.
   line_word_type  cur_word_ff, cur_word_in;
   logic [PIXEL_W-1:0] prev_center_ff;
   line_word_type  next_word;
   line_word_type  store_wdata;
   logic [PIXEL_W-1:0] cur_pixel;
   window_type     window;
   logic [PIXEL_W-1:0] mean;

   // Result register.
   logic               rsp_valid_ff, rsp_valid_in;
   logic [PIXEL_W-1:0] rsp_blurred_value_ff;
   logic               rsp_end_of_row_ff, rsp_end_of_frame_ff;

   logic accept;
   logic produce;
   logic csr_hit;

   // A beat goes in whenever the result register is free or being emptied.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   // Effective frame size: zero acts as one, and the size is capped at the maximum.
   always_comb begin
      if (frame_width_ff == '0) begin
         eff_width = WCW'(1);
      end else if (32'(frame_width_ff) > 32'(WIDTH_MAX)) begin
         eff_width = WCW'(WIDTH_MAX);
      end else begin
         eff_width = WCW'(frame_width_ff);
      end
      if (frame_height_ff == '0) begin
         eff_height = RW'(1);
      end else if (32'(frame_height_ff) > 32'(HEIGHT_MAX)) begin
         eff_height = RW'(HEIGHT_MAX);
      end else begin
         eff_height = RW'(frame_height_ff);
      end
   end

   // The next two columns in scan order, wrapped at the row end.
   always_comb begin
      col_plus1   = WCW'(col_ff) + WCW'(1);
      last_col    = (col_plus1 == eff_width);
      next1_col   = last_col ? '0 : col_plus1[CW-1:0];
      next1_plus1 = WCW'(next1_col) + WCW'(1);
      next2_col   = (next1_plus1 == eff_width) ? '0 : next1_plus1[CW-1:0];
   end

   // Window around the output pixel one row above the incoming beat.
   always_comb begin
      cur_pixel     = (row_ff < eff_height) ? req_pixel_value : '0;
      window.top    = (row_ff >= RW'(2)) ? cur_word_ff.upper : '0;
      window.left   = (col_ff != '0) ? prev_center_ff : '0;
      window.center = cur_word_ff.middle;
      window.right  = last_col ? '0 : next_word.middle;
      window.bottom = cur_pixel;
      store_wdata.upper  = cur_word_ff.middle;
      store_wdata.middle = cur_pixel;
      produce       = (row_ff != '0);
   end

   cmb_line_store #(
      .DEPTH (WIDTH_MAX)
   ) u_line_store (
      .clock         (clock),
      .write_enable  (accept),
      .write_address (col_ff),
      .write_data    (store_wdata),
      .read_enable   (accept),
      .read_address  (next2_col),
      .read_data     (next_word)
   );

   cmb_mean5 u_mean5 (
      .window (window),
      .mean   (mean)
   );

   // Configuration writes and the scan counters; a write to a register restarts the frame.
   always_comb begin
      frame_width_in  = frame_width_ff;
      frame_height_in = frame_height_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      csr_hit         = 1'b0;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_in = csr_write_data[FRAME_WIDTH_W-1:0];
               csr_hit        = 1'b1;
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_in = csr_write_data;
               csr_hit         = 1'b1;
            end
            default: begin
               csr_hit = 1'b0;
            end
         endcase
      end
      if (csr_hit) begin
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         col_in = next1_col;
         if (last_col) begin
            row_in = (row_ff == eff_height) ? '0 : row_ff + RW'(1);
         end
      end
   end

   // Window shift: a one-column row re-reads the word it has just written.
   assign cur_word_in = (next1_col == col_ff) ? store_wdata : next_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RESET;
         frame_height_ff <= FRAME_HEIGHT_RESET;
         col_ff          <= '0;
         row_ff          <= '0;
      end else begin
         frame_width_ff  <= frame_width_in;
         frame_height_ff <= frame_height_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_word_ff    <= cur_word_in;
         prev_center_ff <= cur_word_ff.middle;
      end
   end

   // Result register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (accept && produce) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && produce) begin
         rsp_blurred_value_ff <= mean;
         rsp_end_of_row_ff    <= last_col;
         rsp_end_of_frame_ff  <= last_col && (row_ff == eff_height);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_blurred_value = rsp_blurred_value_ff;
   assign rsp_end_of_row    = rsp_end_of_row_ff;
   assign rsp_end_of_frame  = rsp_end_of_frame_ff;

endmodule

### rtl/cmb_checker.sv
// Port-level checks of the cross mean filter, bound to the top level.
// Depends on cmb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module cmb_checker
   import cmb_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_ready,
   input  logic                rsp_valid,
   input  logic                rsp_ready,
   input  logic [PIXEL_W-1:0]  rsp_blurred_value,
   input  logic                rsp_end_of_row,
   input  logic                rsp_end_of_frame
);

   // A result that is not taken stays, unchanged.
   `CMB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_blurred_value) && $stable(rsp_end_of_row) && $stable(rsp_end_of_frame))

   // The frame ends only on a row end.
   `CMB_ASSERT_IMP(a_eof_on_eor, clock, reset, rsp_valid && rsp_end_of_frame, rsp_end_of_row)

   // No result is pending right after reset.
   `CMB_ASSERT_IMP(a_reset_empty, clock, 1'b0, $past(reset), !rsp_valid)

   // A new result only follows an accepted input beat.
   `CMB_ASSERT_IMP(a_rsp_from_req, clock, reset, $rose(rsp_valid), $past(req_valid && req_ready))

   // A stalled result holds back the input.
   `CMB_ASSERT_IMP(a_backpressure, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule

bind cross_mean_blur_filter cmb_checker u_cmb_checker (.*);
